[hw/rtl/set_assoc_lru_tag_cache_defines.svh]
// assertion macros used by the cache back end rtl
`ifndef SET_ASSOC_LRU_TAG_CACHE_DEFINES_SVH
`define SET_ASSOC_LRU_TAG_CACHE_DEFINES_SVH

// check a property on the rising clock edge, skipped while in reset
`define SALC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check a property on the rising clock edge at all times
`define SALC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[hw/rtl/salc_pkg.sv]
package salc_pkg;

    localparam int unsigned CMD_W    = 1;
    localparam int unsigned IN_ADDR_W = 32;
    localparam int unsigned WAY_W    = 3;
    localparam int unsigned EV_W     = 32;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [IN_ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic            hit;
        logic [WAY_W-1:0] way;
        logic            evicted_valid;
        logic [EV_W-1:0] evicted_address;
    } t_resp;

endpackage

[hw/rtl/salc_front.sv]
module salc_front
    import salc_pkg::*;
#(
    parameter int unsigned ADDR_WIDTH = 32,
    parameter int unsigned SETS       = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_req                    i_req,
    input  logic                    i_full,
    output logic                    o_push,
    output logic                    o_is_write,
    output logic [ADDR_WIDTH-1:0]   o_addr,
    output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] o_set
);
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;

    logic [63:0]           w_ext;
    logic [ADDR_WIDTH-1:0] w_addr;

    // reduce the address to its stored width and pick out the set
    assign w_ext  = 64'(i_req.address);
    assign w_addr = w_ext[ADDR_WIDTH-1:0];

    always_comb begin
        o_push     = i_valid && !i_full;
        o_is_write = (i_req.cmd == CMD_WRITE);
        o_addr     = w_addr;
        if (SETS > 1) begin
            o_set = SET_W'(w_addr % SETS);
        end else begin
            o_set = '0;
        end
    end

    logic r_unused;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unused <= 1'b0;
        end else begin
            r_unused <= r_unused;
        end
    end
endmodule

[hw/rtl/salc_queue.sv]
module salc_queue
    import salc_pkg::*;
#(
    parameter int unsigned W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

[hw/rtl/salc_back.sv]
`include "set_assoc_lru_tag_cache_defines.svh"
module salc_back
    import salc_pkg::*;
#(
    parameter int unsigned WAYS       = 8,
    parameter int unsigned SETS       = 128,
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_is_write,
    input  logic [ADDR_WIDTH-1:0] i_addr,
    input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] i_set,
    output logic                  o_pop,
    output logic                  o_done,
    output t_resp                 o_resp
);
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned WI_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned RK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned ROW_W = WAYS * (ADDR_WIDTH + RK_W);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    // one row per set: tags and ranks of all ways, valid bits held apart
    logic [ROW_W-1:0] r_mem [SETS];
    logic [ROW_W-1:0] r_row;
    logic [WAYS-1:0]  r_vmem [SETS];
    logic [WAYS-1:0]  r_vrow;

    logic [1:0]            r_state, n_state;
    logic [SET_W:0]        r_clr;
    logic                  r_wr;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [SET_W-1:0]      r_set;

    logic [ADDR_WIDTH-1:0] w_tag  [WAYS];
    logic [RK_W-1:0]       w_rank [WAYS];
    logic [WAYS-1:0]       w_match;
    logic                  w_hit;
    logic [WI_W-1:0]       w_hway, w_iway, w_lway, w_way;
    logic                  w_has_inv;
    logic [RK_W-1:0]       w_best, w_old;
    logic                  w_old_valid;
    logic                  w_update;
    logic [ROW_W-1:0]      w_newrow;
    logic [WAYS-1:0]       w_newv;
    t_resp                 w_resp;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_tag[i]  = r_row[i*(ADDR_WIDTH+RK_W) +: ADDR_WIDTH];
            w_rank[i] = r_row[i*(ADDR_WIDTH+RK_W)+ADDR_WIDTH +: RK_W];
            w_match[i] = r_vrow[i] && (w_tag[i] == r_addr);
        end
    end

    always_comb begin
        w_hit = |w_match;
        w_hway = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hway = WI_W'(i);
            end
        end
        w_has_inv = ~&r_vrow;
        w_iway = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!r_vrow[i]) begin
                w_iway = WI_W'(i);
            end
        end
        // lowest way with the largest rank
        w_lway = '0;
        w_best = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (w_rank[i] > w_best) begin
                w_best = w_rank[i];
                w_lway = WI_W'(i);
            end
        end
        if (w_hit) begin
            w_way = w_hway;
        end else if (w_has_inv) begin
            w_way = w_iway;
        end else begin
            w_way = w_lway;
        end
        w_update = w_hit || r_wr;
        w_old_valid = r_vrow[w_way];
        w_old = w_rank[w_way];
    end

    always_comb begin
        w_newrow = r_row;
        w_newv   = r_vrow;
        for (int i = 0; i < WAYS; i++) begin
            if (WI_W'(i) == w_way) begin
                w_newrow[i*(ADDR_WIDTH+RK_W)+ADDR_WIDTH +: RK_W] = '0;
                w_newrow[i*(ADDR_WIDTH+RK_W) +: ADDR_WIDTH] = r_addr;
                w_newv[i] = 1'b1;
            end else if (r_vrow[i] && (!w_old_valid || w_rank[i] < w_old)) begin
                w_newrow[i*(ADDR_WIDTH+RK_W)+ADDR_WIDTH +: RK_W] = w_rank[i] + 1'b1;
            end
        end
    end

    always_comb begin
        w_resp = '0;
        w_resp.hit = w_hit;
        if (w_update) begin
            w_resp.way = WAY_W'(w_way);
        end
        if (!w_hit && r_wr && !w_has_inv) begin
            w_resp.evicted_valid   = 1'b1;
            w_resp.evicted_address = EV_W'(w_tag[w_lway]);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == (SET_W+1)'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE:  if (i_valid) n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_pop = (r_state == ST_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_row  <= r_mem[r_set];
            r_vrow <= r_vmem[r_set];
        end
        if (r_state == ST_CLEAR) begin
            r_vmem[r_clr[SET_W-1:0]] <= '0;
        end else if (r_state == ST_EXEC && w_update) begin
            r_mem[r_set]  <= w_newrow;
            r_vmem[r_set] <= w_newv;
        end
        if (o_pop) begin
            r_wr   <= i_is_write;
            r_addr <= i_addr;
            r_set  <= i_set;
        end
        o_resp <= w_resp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            o_done <= (r_state == ST_EXEC);
        end
    end

    `SALC_ASSERT(a_pop_idle, o_pop |-> r_state == ST_IDLE, "pop outside idle")
    `SALC_ASSERT(a_done_seq, o_done |-> $past(r_state) == ST_EXEC, "done without exec")
    `SALC_ASSERT(a_read_evict, (o_done && !$past(r_wr)) |-> !o_resp.evicted_valid, "read evicted")
    `SALC_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> r_state == ST_CLEAR, "reset not clearing")
endmodule

[hw/rtl/set_assoc_lru_tag_cache.sv]
// with the back end idle the result strobe follows the accepting edge through the registered
// steps queue pop, tag row read and update; one request is in the back end at a time, so a
// new one is taken only once the read-modify-write of a set's row is done
// after reset a clearing pass over every set empties the valid bits; up to two requests
// are queued meanwhile, then busy rises; the result strobe lasts one cycle, no stall
module set_assoc_lru_tag_cache
    import salc_pkg::*;
#(
    parameter int unsigned WAYS       = 8,
    parameter int unsigned SETS       = 128,
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    output logic  o_strobe,
    output t_resp o_resp
);
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned QW    = 1 + ADDR_WIDTH + SET_W;

    logic                  w_push, w_isw, w_full, w_qv, w_pop;
    logic [ADDR_WIDTH-1:0] w_addr;
    logic [SET_W-1:0]      w_set;
    logic [QW-1:0]         w_qd;

    salc_front #(.ADDR_WIDTH(ADDR_WIDTH), .SETS(SETS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start), .i_req(i_req),
        .i_full(w_full), .o_push(w_push), .o_is_write(w_isw),
        .o_addr(w_addr), .o_set(w_set)
    );

    salc_queue #(.W(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push),
        .i_data({w_isw, w_addr, w_set}), .i_pop(w_pop),
        .o_full(w_full), .o_valid(w_qv), .o_data(w_qd)
    );

    salc_back #(.WAYS(WAYS), .SETS(SETS), .ADDR_WIDTH(ADDR_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv),
        .i_is_write(w_qd[QW-1]), .i_addr(w_qd[SET_W +: ADDR_WIDTH]),
        .i_set(w_qd[SET_W-1:0]), .o_pop(w_pop), .o_done(o_strobe), .o_resp(o_resp)
    );

    assign busy = w_full;
endmodule

[tb/sv/tb_set_assoc_lru_tag_cache.sv]
module tb_set_assoc_lru_tag_cache;
    import salc_pkg::*;

    localparam int unsigned N_WAYS = 8;
    localparam int unsigned N_SETS = 128;
    localparam int unsigned N_RANDOM = 1030;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_req  i_req = '0;
    logic  o_strobe;
    t_resp o_resp;

    set_assoc_lru_tag_cache #(
        .WAYS(N_WAYS),
        .SETS(N_SETS),
        .ADDR_WIDTH(32)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_resp  (o_resp)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [31:0] line_tag [N_SETS][N_WAYS];
    bit          line_vld [N_SETS][N_WAYS];
    int unsigned line_age [N_SETS][N_WAYS];

    t_req  req_q[$];
    t_resp lookup_q[$];
    int    err_count = 0;
    bit    stim_done = 0;
    bit    calm = 0;
    int    gap = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic void make_recent(input int s, input int w);
        int unsigned prev;
        prev = line_vld[s][w] ? line_age[s][w] : N_WAYS;
        for (int i = 0; i < N_WAYS; i++)
            if (i != w && line_vld[s][i] && line_age[s][i] < prev)
                line_age[s][i]++;
        line_age[s][w] = 0;
    endfunction

    function automatic t_resp predict_lookup(input t_req r);
        t_resp res;
        int s, w, i;
        bit found, empty;
        int unsigned best;
        res = '0;
        s = r.address % N_SETS;
        found = 0;
        w = 0;
        for (i = 0; i < N_WAYS; i++)
            if (!found && line_vld[s][i] && line_tag[s][i] == r.address) begin
                w = i;
                found = 1;
            end
        if (found) begin
            res.hit = 1'b1;
            res.way = w[WAY_W-1:0];
            make_recent(s, w);
        end else if (r.cmd == CMD_WRITE) begin
            empty = 0;
            for (i = 0; i < N_WAYS; i++)
                if (!empty && !line_vld[s][i]) begin
                    w = i;
                    empty = 1;
                end
            if (!empty) begin
                w = 0;
                best = 0;
                for (i = 0; i < N_WAYS; i++)
                    if (line_age[s][i] > best) begin
                        best = line_age[s][i];
                        w = i;
                    end
                res.evicted_valid = 1'b1;
                res.evicted_address = line_tag[s][w];
            end
            make_recent(s, w);
            line_tag[s][w] = r.address;
            line_vld[s][w] = 1;
            res.way = w[WAY_W-1:0];
        end
        return res;
    endfunction

    function automatic t_req mk(input logic c, input logic [31:0] a);
        t_req r;
        r.cmd = c;
        r.address = a;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) lookup_q.push_back(predict_lookup(i_req));
            if (!start || !busy) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    start <= 1'b0;
                end else if (!calm && $urandom_range(0, 19) == 0) begin
                    gap <= $urandom_range(1, 15) - 1;
                    start <= 1'b0;
                end else if (req_q.size() > 0) begin
                    i_req <= req_q.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_resp exp_r;
        if (i_rst_n && o_strobe) begin
            if (lookup_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                exp_r = lookup_q.pop_front();
                if (o_resp.hit !== exp_r.hit)
                    report_mismatch($sformatf("hit %0b exp %0b", o_resp.hit, exp_r.hit));
                if (o_resp.way !== exp_r.way)
                    report_mismatch($sformatf("way %0d exp %0d", o_resp.way, exp_r.way));
                if (o_resp.evicted_valid !== exp_r.evicted_valid)
                    report_mismatch($sformatf("evicted_valid %0b exp %0b",
                        o_resp.evicted_valid, exp_r.evicted_valid));
                if (o_resp.evicted_address !== exp_r.evicted_address)
                    report_mismatch($sformatf("evicted_address %h exp %h",
                        o_resp.evicted_address, exp_r.evicted_address));
            end
        end
    end

    initial begin
        logic [31:0] hot [$];
        logic [31:0] a;
        int k;
        for (int s = 0; s < N_SETS; s++)
            for (int w = 0; w < N_WAYS; w++) begin
                line_tag[s][w] = '0;
                line_vld[s][w] = 0;
                line_age[s][w] = 0;
            end
        // directed: extremes, read miss, fill, hit, eviction in set 0 and set 127
        req_q.push_back(mk(CMD_READ, 32'h0));
        req_q.push_back(mk(CMD_WRITE, 32'h0));
        req_q.push_back(mk(CMD_READ, 32'h0));
        req_q.push_back(mk(CMD_WRITE, 32'h0));
        req_q.push_back(mk(CMD_WRITE, 32'hFFFF_FFFF));
        req_q.push_back(mk(CMD_READ, 32'hFFFF_FFFF));
        for (int i = 1; i <= 8; i++)
            req_q.push_back(mk(CMD_WRITE, i * N_SETS));
        req_q.push_back(mk(CMD_READ, 32'h0));
        req_q.push_back(mk(CMD_WRITE, 32'hAAAA_AA80));
        req_q.push_back(mk(CMD_WRITE, 32'h5555_5500));
        req_q.push_back(mk(CMD_READ, 32'h8000_0000));
        req_q.push_back(mk(CMD_WRITE, 32'h8000_0000));
        for (int i = 1; i <= 8; i++)
            req_q.push_back(mk(CMD_WRITE, 32'hFFFF_FFFF - i * N_SETS));

        // random: mostly a small working set so hits and evictions both occur
        for (int i = 0; i < 40; i++)
            hot.push_back({25'($urandom_range(0, 63)), 7'($urandom_range(0, 3))});
        for (int i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(0, 9);
            if (k < 7) a = hot[$urandom_range(0, hot.size() - 1)];
            else if (k < 8) a = {25'($urandom_range(0, 15)), 7'($urandom_range(0, 3))};
            else a = $urandom;
            req_q.push_back(mk(1'($urandom_range(0, 1)), a));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (req_q.size() > 100) @(posedge i_clk);
        calm = 1;
        while (req_q.size() > 0 || start) @(posedge i_clk);
        while (lookup_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
